@@ design/led_driver_chain_frame_serializer_top_assert.svh @@
// assertion macros shared by the serializer modules
`ifndef LED_DRIVER_CHAIN_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define LED_DRIVER_CHAIN_FRAME_SERIALIZER_TOP_ASSERT_SVH

// checked only outside reset
`define LDCFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LDCFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ldcfs_pkg.sv @@
`default_nettype none

package ldcfs_pkg;

    localparam int CHAIN_LENGTH = 2;
    localparam int FRAME_BITS   = 16 * CHAIN_LENGTH;
    localparam int BIT_W        = $clog2(FRAME_BITS);
    localparam int BYTE_W       = BIT_W - 3;
    localparam int SLOT_W       = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);

    localparam logic CMD_RAW   = 1'b0;
    localparam logic CMD_GLYPH = 1'b1;

    localparam logic [7:0] SEG_GLYPHS [16] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
    };

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [7:0]        addr;
        logic [7:0]        data;
    } entry_t;

    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        logic [7:0] idx;
        begin
            if (ch >= 8'h30 && ch <= 8'h39)
                idx = ch - 8'h30;
            else if (ch >= 8'h61 && ch <= 8'h66)
                idx = ch - 8'h57;
            else if (ch >= 8'h41 && ch <= 8'h46)
                idx = ch - 8'h37;
            else if (ch <= 8'h0F)
                idx = ch;
            else
                idx = 8'h00;
            return SEG_GLYPHS[idx[3:0]];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/ldcfs_front.sv @@
`default_nettype none

module ldcfs_front (
    input  wire logic            push,
    input  wire logic            q_full,
    input  wire logic            cmd,
    input  wire logic [7:0]      device_index,
    input  wire logic [7:0]      reg_address,
    input  wire logic [7:0]      payload,
    output logic                 full,
    output logic                 q_push,
    output ldcfs_pkg::entry_t    q_entry
);
    import ldcfs_pkg::*;

    logic in_range;

    assign in_range = device_index < 8'(CHAIN_LENGTH);
    assign full     = q_full;
    assign q_push   = push && !q_full && in_range;

    always_comb
    begin
        q_entry.slot = SLOT_W'(CHAIN_LENGTH - 1) - device_index[SLOT_W-1:0];
        q_entry.addr = reg_address;
        unique case (cmd)
            CMD_GLYPH: q_entry.data = glyph_of(payload);
            CMD_RAW:   q_entry.data = payload;
            default:   q_entry.data = payload;
        endcase
    end

endmodule

`default_nettype wire

@@ design/ldcfs_queue.sv @@
`default_nettype none

module ldcfs_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire ldcfs_pkg::entry_t wr_entry,
    input  wire logic            rd_en,
    output ldcfs_pkg::entry_t    rd_entry,
    output logic                 q_full,
    output logic                 q_empty
);
    import ldcfs_pkg::*;

    `include "led_driver_chain_frame_serializer_top_assert.svh"

    entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign q_full   = cnt_reg == Q_CW'(Q_DEPTH);
    assign q_empty  = cnt_reg == '0;
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    `LDCFS_ASSERT_ALWAYS(a_cnt_bound, !rst_n || cnt_reg <= Q_CW'(Q_DEPTH), "queue count over depth")
    `LDCFS_ASSERT(a_wr_only_grows, do_wr && !do_rd |=> cnt_reg == $past(cnt_reg) + 1'b1,
        "queue count did not grow on write")

endmodule

`default_nettype wire

@@ design/ldcfs_back.sv @@
`default_nettype none

module ldcfs_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire ldcfs_pkg::entry_t q_entry,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 serial_bit,
    output logic                 frame_end
);
    import ldcfs_pkg::*;

    `include "led_driver_chain_frame_serializer_top_assert.svh"

    logic              busy_reg, busy_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    entry_t            entry_reg;
    logic [BYTE_W-1:0] byte_idx;
    logic [7:0]        cur_byte;
    logic              beat;
    logic              slot_hit;

    assign empty     = !busy_reg;
    assign beat      = busy_reg && pop;
    assign frame_end = bit_cnt_reg == BIT_W'(FRAME_BITS - 1);
    assign q_pop     = !q_empty && (!busy_reg || (beat && frame_end));

    assign byte_idx   = bit_cnt_reg[BIT_W-1:3];
    assign slot_hit   = BYTE_W'(entry_reg.slot) == BYTE_W'(byte_idx >> 1);
    assign cur_byte   = !slot_hit ? 8'h00 : (byte_idx[0] ? entry_reg.data : entry_reg.addr);
    assign serial_bit = cur_byte[~bit_cnt_reg[2:0]];

    always_comb
    begin
        busy_next    = busy_reg;
        bit_cnt_next = bit_cnt_reg;
        if (q_pop)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
        end
        else if (beat)
        begin
            if (frame_end)
                busy_next = 1'b0;
            else
                bit_cnt_next = bit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            entry_reg <= q_entry;
    end

    `LDCFS_ASSERT(a_hold_on_stall, busy_reg && !pop |=> $stable(bit_cnt_reg) && busy_reg,
        "frame position moved without a beat")
    `LDCFS_ASSERT(a_restart_at_zero, q_pop |=> busy_reg && bit_cnt_reg == '0,
        "new frame did not start at first bit")
    `LDCFS_ASSERT(a_no_load_mid_frame, busy_reg && !(pop && frame_end) |-> !q_pop,
        "item loaded in the middle of a frame")

endmodule

`default_nettype wire

@@ design/led_driver_chain_frame_serializer_top.sv @@
// channel  | handshake     | beat fields
// ---------+---------------+-------------------------------------------
// item in  | push / full   | cmd, device_index, reg_address, payload
// bit out  | empty / pop   | serial_bit, frame_end
//
// each in-range item yields 16 * CHAIN_LENGTH bit beats, one per cycle while pop is high
// the serializer bit counter paces the items: a queued item loads only with the last bit beat of a frame or when idle
// a two-entry queue lets new items in while a frame is still shifting out
// out-of-range device index: item taken, no beats produced
// asynchronous active-low reset empties the queue and the serializer
`default_nettype none

module led_driver_chain_frame_serializer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       cmd,
    input  wire logic [7:0] device_index,
    input  wire logic [7:0] reg_address,
    input  wire logic [7:0] payload,
    output logic            empty,
    input  wire logic       pop,
    output logic            serial_bit,
    output logic            frame_end
);
    import ldcfs_pkg::*;

    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    entry_t q_wr_entry;
    entry_t q_rd_entry;

    ldcfs_front u_front (
        .push         (push),
        .q_full       (q_full),
        .cmd          (cmd),
        .device_index (device_index),
        .reg_address  (reg_address),
        .payload      (payload),
        .full         (full),
        .q_push       (q_push),
        .q_entry      (q_wr_entry)
    );

    ldcfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    ldcfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_entry    (q_rd_entry),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .serial_bit (serial_bit),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
